FILE: hdl/ogf_pkg.sv
// Shared types and constants for the overlap group unique full filter.
// Holds the record, result, queue entry and configuration structs.
// No dependencies.
package ogf_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_EDGE_SLACK         = 2'd0;
  localparam logic [1:0] REG_SPAN_PERCENT       = 2'd1;
  localparam logic [1:0] REG_IDENTITY_THRESHOLD = 2'd2;

  localparam logic [15:0] EDGE_SLACK_RESET         = 16'd100;
  localparam logic [6:0]  SPAN_PERCENT_RESET       = 7'd60;
  localparam logic [13:0] IDENTITY_THRESHOLD_RESET = 14'd9000;

  localparam logic [6:0] SPAN_SCALE = 7'd100;
  localparam logic [1:0] COUNT_MAX  = 2'd3;

  typedef struct packed {
    logic [31:0] query_id;
    logic [31:0] subject_id;
    logic [31:0] query_start;
    logic [31:0] query_end;
    logic [31:0] query_size;
    logic [31:0] subject_start;
    logic [31:0] subject_end;
    logic [31:0] subject_size;
    logic [1:0]  directions;
    logic [13:0] identity;
    logic        query_flagged;
    logic        last_in_group;
  } in_t;

  typedef struct packed {
    logic [31:0] out_query_id;
    logic [31:0] out_subject_id;
    logic [31:0] out_query_start;
    logic [31:0] out_query_end;
    logic [31:0] out_query_size;
    logic        out_query_reverse;
    logic [31:0] out_subject_start;
    logic [31:0] out_subject_end;
    logic [31:0] out_subject_size;
    logic [13:0] out_identity;
  } out_t;

  typedef struct packed {
    logic full;
    logic last;
    in_t  rec;
  } mid_t;

  typedef struct packed {
    logic [15:0] edge_slack;
    logic [6:0]  span_percent;
    logic [13:0] identity_threshold;
  } cfg_t;

endpackage

FILE: hdl/ogf_fifo.sv
// Small synchronous FIFO of registers, used between the front and back parts
// and for finished results. Depends on nothing but its type parameter.
module ogf_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  T                           wdata,
  input  logic                       pop,
  output T                           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  T            mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/ogf_front.sv
// Front part: two-stage classification pipeline that marks each record full or not.
// Depends on ogf_pkg for the record, queue entry and configuration types.
module ogf_front #(
  parameter int COORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ogf_pkg::in_t  in_rec,
  input  ogf_pkg::cfg_t cfg,
  output logic          out_valid,
  output ogf_pkg::mid_t out_entry,
  output logic [1:0]    pending
);

  import ogf_pkg::*;

  localparam int CB = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int DW = CB + 2;
  localparam int PW = CB + 7;

  function automatic logic signed [DW-1:0] ext(input logic [31:0] v);
    return signed'({2'b00, v[CB-1:0]});
  endfunction

  logic signed [DW-1:0] qo, qe, qs, so, se, ss, e;
  logic signed [DW-1:0] qb, qn, sb, sn;
  logic                 cont_c, dove_c;

  logic                 s1_valid;
  in_t                  s1_rec;
  logic                 s1_cont, s1_dove;
  logic signed [DW-1:0] s1_qspan, s1_sspan;
  logic [CB-1:0]        s1_qs, s1_ss;

  logic                 s2_valid;
  in_t                  s2_rec;
  logic                 s2_cont, s2_dove;
  logic                 s2_qpos, s2_spos;
  logic [PW-1:0]        s2_qlhs, s2_qrhs, s2_slhs, s2_srhs;
  logic                 spans_c;

  always_comb begin
    qo = ext(in_rec.query_start);
    qe = ext(in_rec.query_end);
    qs = ext(in_rec.query_size);
    so = ext(in_rec.subject_start);
    se = ext(in_rec.subject_end);
    ss = ext(in_rec.subject_size);
    e  = signed'({{(DW-16){1'b0}}, cfg.edge_slack});
    qb = in_rec.directions[0] ? qs - qe : qo;
    qn = in_rec.directions[0] ? qs - qo : qe;
    sb = in_rec.directions[1] ? ss - se : so;
    sn = in_rec.directions[1] ? ss - so : se;
    cont_c = (qo <= e && qs - qe <= e) || (so <= e && ss - se <= e);
    dove_c = (qs - qn <= e && sb <= e) || (ss - sn <= e && qb <= e);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_rec   <= in_rec;
    s1_cont  <= cont_c;
    s1_dove  <= dove_c;
    s1_qspan <= qn - qb;
    s1_sspan <= sn - sb;
    s1_qs    <= in_rec.query_size[CB-1:0];
    s1_ss    <= in_rec.subject_size[CB-1:0];

    s2_rec  <= s1_rec;
    s2_cont <= s1_cont;
    s2_dove <= s1_dove;
    s2_qpos <= !s1_qspan[DW-1];
    s2_spos <= !s1_sspan[DW-1];
    s2_qlhs <= PW'(s1_qspan[CB-1:0]) * PW'(SPAN_SCALE);
    s2_slhs <= PW'(s1_sspan[CB-1:0]) * PW'(SPAN_SCALE);
    s2_qrhs <= PW'(s1_qs) * PW'(cfg.span_percent);
    s2_srhs <= PW'(s1_ss) * PW'(cfg.span_percent);
  end

  assign spans_c = (s2_qpos && s2_qlhs >= s2_qrhs) || (s2_spos && s2_slhs >= s2_srhs);

  assign out_valid      = s2_valid;
  assign out_entry.full = !s2_rec.query_flagged && (s2_cont || (s2_dove && spans_c));
  assign out_entry.last = s2_rec.last_in_group;
  assign out_entry.rec  = s2_rec;
  assign pending        = {1'b0, s1_valid} + {1'b0, s2_valid};

endmodule

FILE: hdl/ogf_back.sv
// Back part: counts full records per group, keeps the last one and decides at group end.
// Depends on ogf_pkg for the queue entry, result and configuration types.
module ogf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          mid_empty,
  input  ogf_pkg::mid_t mid_entry,
  output logic          mid_pop,
  input  ogf_pkg::cfg_t cfg,
  input  logic          res_full,
  output logic          res_push,
  output ogf_pkg::out_t res_data
);

  import ogf_pkg::*;

  logic [1:0] full_count;
  logic [1:0] full_count_next;
  logic [1:0] count_after;
  in_t        kept;
  in_t        kept_next;

  always_comb begin
    mid_pop     = !mid_empty && !res_full;
    count_after = full_count;
    kept_next   = kept;
    if (mid_entry.full) begin
      count_after = (full_count == COUNT_MAX) ? COUNT_MAX : full_count + 2'd1;
      kept_next   = mid_entry.rec;
    end
    full_count_next = mid_entry.last ? 2'd0 : count_after;
    res_push = mid_pop && mid_entry.last && count_after == 2'd1 &&
               kept_next.identity >= cfg.identity_threshold;

    res_data.out_query_id      = kept_next.query_id;
    res_data.out_subject_id    = kept_next.subject_id;
    res_data.out_query_start   = kept_next.query_start;
    res_data.out_query_end     = kept_next.query_end;
    res_data.out_query_size    = kept_next.query_size;
    res_data.out_query_reverse = kept_next.directions[0] ^ kept_next.directions[1];
    res_data.out_subject_start = kept_next.subject_start;
    res_data.out_subject_end   = kept_next.subject_end;
    res_data.out_subject_size  = kept_next.subject_size;
    res_data.out_identity      = kept_next.identity;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_count <= 2'd0;
    end else if (mid_pop) begin
      full_count <= full_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      kept <= kept_next;
    end
  end

endmodule

FILE: hdl/overlap_group_unique_full_filter_top.sv
// A group's result is pushed to the result queue when its last record leaves the middle queue.
// Throughput: one record per cycle; full rises once the middle queue and the two
// classification stages together hold QUEUE_DEPTH records, and the back part stalls
// while the two-entry result queue is full.
// Reset (synchronous, rst high): registers return to 100, 60 and 9000, queues empty,
// full count cleared.
module overlap_group_unique_full_filter_top #(
  parameter int COORD_BITS  = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  ogf_pkg::in_t                  item,
  output logic                          empty,
  input  logic                          pop,
  output ogf_pkg::out_t                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ogf_pkg::ADDR_W-1:0]    paddr,
  input  logic [ogf_pkg::DATA_W-1:0]    pwdata,
  output logic [ogf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  import ogf_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  cfg_t          cfg;
  logic [1:0]    reg_index;
  logic          in_take;
  logic          front_valid;
  mid_t          front_entry;
  logic [1:0]    pending;
  mid_t          mid_entry;
  logic          mid_full;
  logic          mid_empty;
  logic          mid_pop;
  logic [CW-1:0] mid_count;
  logic [CW:0]   occupancy;
  logic          res_push;
  out_t          res_data;
  logic          res_full;
  logic [1:0]    res_count;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_slack         <= EDGE_SLACK_RESET;
      cfg.span_percent       <= SPAN_PERCENT_RESET;
      cfg.identity_threshold <= IDENTITY_THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_EDGE_SLACK:         cfg.edge_slack         <= pwdata[15:0];
        REG_SPAN_PERCENT:       cfg.span_percent       <= pwdata[6:0];
        REG_IDENTITY_THRESHOLD: cfg.identity_threshold <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_EDGE_SLACK:         prdata = {16'd0, cfg.edge_slack};
      REG_SPAN_PERCENT:       prdata = {25'd0, cfg.span_percent};
      REG_IDENTITY_THRESHOLD: prdata = {18'd0, cfg.identity_threshold};
      default:                prdata = '0;
    endcase
  end

  assign occupancy = (CW+1)'(mid_count) + (CW+1)'(pending);
  assign full      = (occupancy >= (CW+1)'(QUEUE_DEPTH));
  assign in_take   = push && !full;

  ogf_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_take),
    .in_rec   (item),
    .cfg      (cfg),
    .out_valid(front_valid),
    .out_entry(front_entry),
    .pending  (pending)
  );

  ogf_fifo #(
    .T    (mid_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_valid),
    .wdata(front_entry),
    .pop  (mid_pop),
    .rdata(mid_entry),
    .full (mid_full),
    .empty(mid_empty),
    .count(mid_count)
  );

  ogf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_empty(mid_empty),
    .mid_entry(mid_entry),
    .mid_pop  (mid_pop),
    .cfg      (cfg),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  ogf_fifo #(
    .T    (out_t),
    .DEPTH(2)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_data),
    .pop  (pop),
    .rdata(result),
    .full (res_full),
    .empty(empty),
    .count(res_count)
  );

  // The credit scheme must never let a classified record reach a full middle queue.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (CW+1)'(QUEUE_DEPTH))
    else $error("middle queue plus pipeline exceeds its depth");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    front_valid |-> !mid_full)
    else $error("classified record arrives at a full middle queue");

  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (mid_pop && !res_full && res_count != 2'd2))
    else $error("result pushed without a group end taken");

  a_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_take |=> pending != 2'd0)
    else $error("accepted transaction missing from the pipeline");

endmodule
